/* rtl/fbs_pkg.sv */
// shared types and constants of the flipbook bilinear sampler
package fbs_pkg;

	// widths of the tap address, tap weight and mixed channel sum
	localparam int LIN_W = 33;
	localparam int W_W   = 33;
	localparam int MIX_W = 41;
	localparam int QUEUE_DEPTH = 4;

	// item kinds
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// register indexes
	localparam logic [2:0] REG_GRID_N        = 3'd0;
	localparam logic [2:0] REG_TILES_PER_ROW = 3'd1;
	localparam logic [2:0] REG_FRAME_COUNT   = 3'd2;
	localparam logic [2:0] REG_FIELD_WIDTH   = 3'd3;
	localparam logic [2:0] REG_FIELD_HEIGHT  = 3'd4;
	localparam logic [2:0] REG_VMAX          = 3'd5;
	localparam logic [2:0] REG_FIELD_LOADED  = 3'd6;

	// red and green of a tap outside the field, 0.5 in units of 1/510
	localparam logic [8:0] OUTSIDE_RG = 9'd255;
	// one channel at full scale times 2^32, doubled mix compares against it
	localparam logic [41:0] MIX_FULL = 42'd510 << 32;
	// floor(2^32 / 255), reciprocal for the divide by 510
	localparam logic [24:0] RECIP_255 = 25'd16843009;

	typedef struct packed {
		logic [8:0]  grid_n;
		logic [8:0]  tiles_per_row;
		logic [10:0] frame_count;
		logic [12:0] field_width;
		logic [12:0] field_height;
		logic [15:0] vmax;
		logic        field_loaded;
	} cfg_t;

	// one classified request from front to back
	typedef struct packed {
		logic                  kind;
		logic                  unl;
		logic [3:0]            ok;
		logic [3:0][LIN_W-1:0] lin;
		logic [3:0][W_W-1:0]   w;
		logic [31:0]           bgra;
	} cmd_t;

endpackage

/* rtl/fbs_front.sv */
// front end: clamps, tile lookup and tap addresses and weights per request
module fbs_front #(
	parameter int MAX_TEXELS = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fbs_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_kind,
	input  logic [15:0]         in_idx,
	input  logic [31:0]         in_bgra,
	input  logic signed [17:0]  in_u,
	input  logic signed [17:0]  in_v,
	input  logic [9:0]          in_frame,
	output logic                out_valid,
	input  logic                out_ready,
	output fbs_pkg::cmd_t       out_cmd
);
	import fbs_pkg::*;

	localparam int NST = 13;
	localparam int DIV_BITS = 10;

	typedef struct packed {
		logic                kind;
		logic                unl;
		logic [15:0]         idx;
		logic [31:0]         bgra;
		logic [16:0]         uc;
		logic [16:0]         vc;
		logic [9:0]          f;
		logic [7:0]          rem;
		logic [9:0]          quo;
		logic [24:0]         fx;
		logic [24:0]         fy;
		logic [7:0]          x0;
		logic [7:0]          y0;
		logic [15:0]         sx;
		logic [15:0]         sy;
		logic [3:0][W_W-1:0] w;
		logic [16:0]         bx;
		logic [17:0]         by;
		logic [LIN_W-1:0]    lin;
	} fe_t;

	fe_t              stage_q [NST];
	fe_t              nxt [NST];
	logic [NST-1:0]   vld_q;
	cmd_t             cmd_q;
	cmd_t             cmd_d;
	logic             vcmd_q;
	logic             fadv;
	logic [25:0]      lim_q;
	logic [8:0]       n_eff;
	logic [7:0]       nm2;
	logic [8:0]       tpr_eff;
	logic [10:0]      fm1;
	logic [LIN_W-1:0] max_lin;

	// effective config values
	always_comb begin
		n_eff   = (cfg.grid_n < 9'd2) ? 9'd2 : cfg.grid_n;
		nm2     = 8'(n_eff - 9'd2);
		tpr_eff = (cfg.tiles_per_row == 9'd0) ? 9'd1 : cfg.tiles_per_row;
		fm1     = (cfg.frame_count == 11'd0) ? 11'd0 : cfg.frame_count - 11'd1;
		max_lin = LIN_W'(MAX_TEXELS);
	end

	assign fadv     = !vcmd_q || out_ready;
	assign in_ready = fadv;

	// stage logic
	always_comb begin
		logic [8:0]  r;
		logic [24:0] dx;
		logic [24:0] dy;
		logic [16:0] wx0;
		logic [16:0] wy0;
		logic [16:0] wx1;
		logic [16:0] wy1;
		// capture: clamp frame and position
		nxt[0]      = '0;
		nxt[0].kind = in_kind;
		nxt[0].unl  = !cfg.field_loaded || (cfg.field_width == 13'd0);
		nxt[0].idx  = in_idx;
		nxt[0].bgra = in_bgra;
		nxt[0].f    = ({1'b0, in_frame} > fm1) ? fm1[9:0] : in_frame;
		if (in_u[17]) begin
			nxt[0].uc = 17'd0;
		end else if (in_u > 18'sd65536) begin
			nxt[0].uc = 17'd65536;
		end else begin
			nxt[0].uc = in_u[16:0];
		end
		if (in_v[17]) begin
			nxt[0].vc = 17'd0;
		end else if (in_v > 18'sd65536) begin
			nxt[0].vc = 17'd65536;
		end else begin
			nxt[0].vc = in_v[16:0];
		end
		// restoring divide of frame by tiles per row, one bit a stage
		for (int k = 1; k <= DIV_BITS; k++) begin
			nxt[k] = stage_q[k-1];
			r = {stage_q[k-1].rem, stage_q[k-1].f[DIV_BITS-k]};
			if (r >= tpr_eff) begin
				nxt[k].rem = 8'(r - tpr_eff);
				nxt[k].quo[DIV_BITS-k] = 1'b1;
			end else begin
				nxt[k].rem = r[7:0];
			end
		end
		// position scaled into the tile
		nxt[1].fx = 25'({8'd0, stage_q[0].uc} * {17'd0, nm2}) + 25'd32768;
		nxt[1].fy = 25'({8'd0, stage_q[0].vc} * {17'd0, nm2}) + 25'd32768;
		// base texel and fraction, kept one texel from the edge
		nxt[2].x0 = (stage_q[1].fx[24:16] > {1'b0, nm2}) ? nm2 : stage_q[1].fx[23:16];
		nxt[2].y0 = (stage_q[1].fy[24:16] > {1'b0, nm2}) ? nm2 : stage_q[1].fy[23:16];
		dx = stage_q[1].fx - {1'b0, nxt[2].x0, 16'h0000};
		dy = stage_q[1].fy - {1'b0, nxt[2].y0, 16'h0000};
		nxt[2].sx = (dx > 25'd65535) ? 16'hFFFF : dx[15:0];
		nxt[2].sy = (dy > 25'd65535) ? 16'hFFFF : dy[15:0];
		// tap weights
		wx1 = {1'b0, stage_q[2].sx};
		wy1 = {1'b0, stage_q[2].sy};
		wx0 = 17'd65536 - wx1;
		wy0 = 17'd65536 - wy1;
		nxt[3].w[0] = W_W'({17'd0, wx0} * {17'd0, wy0});
		nxt[3].w[1] = W_W'({17'd0, wx1} * {17'd0, wy0});
		nxt[3].w[2] = W_W'({17'd0, wx0} * {17'd0, wy1});
		nxt[3].w[3] = W_W'({17'd0, wx1} * {17'd0, wy1});
		// texel coordinates in the atlas
		nxt[11]    = stage_q[10];
		nxt[11].bx = 17'({9'd0, stage_q[10].rem} * {8'd0, n_eff}) + {9'd0, stage_q[10].x0};
		nxt[11].by = 18'({9'd0, stage_q[10].quo} * {10'd0, n_eff}) + {10'd0, stage_q[10].y0};
		// linear address of the first tap
		nxt[12]     = stage_q[11];
		nxt[12].lin = LIN_W'({13'd0, stage_q[11].by} * {18'd0, cfg.field_width})
			+ LIN_W'(stage_q[11].bx);
	end

	// request for the queue: sample taps checked against the field and memory size, a write only against memory size
	always_comb begin
		logic [LIN_W-1:0] fw;
		fw           = LIN_W'(cfg.field_width);
		cmd_d        = '0;
		cmd_d.kind   = stage_q[NST-1].kind;
		cmd_d.unl    = stage_q[NST-1].unl;
		cmd_d.bgra   = stage_q[NST-1].bgra;
		cmd_d.w      = stage_q[NST-1].w;
		if (stage_q[NST-1].kind == KIND_WRITE) begin
			cmd_d.lin[0] = LIN_W'(stage_q[NST-1].idx);
			cmd_d.ok[0]  = LIN_W'(stage_q[NST-1].idx) < max_lin;
		end else begin
			cmd_d.lin[0] = stage_q[NST-1].lin;
			cmd_d.lin[1] = stage_q[NST-1].lin + LIN_W'(1);
			cmd_d.lin[2] = stage_q[NST-1].lin + fw;
			cmd_d.lin[3] = stage_q[NST-1].lin + fw + LIN_W'(1);
			for (int t = 0; t < 4; t++) begin
				cmd_d.ok[t] = (cmd_d.lin[t] < LIN_W'(lim_q)) && (cmd_d.lin[t] < max_lin);
			end
		end
	end

	// valid chain and field size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vcmd_q <= 1'b0;
			lim_q  <= '0;
		end else begin
			lim_q <= 26'({13'd0, cfg.field_width} * {13'd0, cfg.field_height});
			if (fadv) begin
				vld_q  <= {vld_q[NST-2:0], in_valid};
				vcmd_q <= vld_q[NST-1];
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (fadv) begin
			for (int k = 0; k < NST; k++) begin
				stage_q[k] <= nxt[k];
			end
			cmd_q <= cmd_d;
		end
	end

	assign out_valid = vcmd_q;
	assign out_cmd   = cmd_q;

endmodule

/* rtl/fbs_queue.sv */
// short request queue between front and back
module fbs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fbs_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output fbs_pkg::cmd_t out_cmd
);
	import fbs_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t        slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = cnt_q != (PW+1)'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = slot_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	// slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_cmd;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(QUEUE_DEPTH))
		else $error("queue count past depth");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + (PW+1)'(1))
		else $error("queue count missed a push");
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !pop)
		else $error("pop from empty queue");
`endif

endmodule

/* rtl/fbs_back.sv */
// back end: texel memory, up to four tap reads, bilinear mix and output scaling
module fbs_back #(
	parameter int MAX_TEXELS = 65536
) (
	input  logic          clk,
	input  logic          arst_n,
	input  fbs_pkg::cfg_t cfg,
	input  logic          q_valid,
	output logic          q_ready,
	input  fbs_pkg::cmd_t q_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [16:0]   vel_x,
	output logic [16:0]   vel_y,
	output logic [15:0]   density,
	output logic [15:0]   solid
);
	import fbs_pkg::*;

	localparam int AW = $clog2(MAX_TEXELS);

	logic [31:0]            tex_mem [MAX_TEXELS];
	cmd_t                   cur_q;
	logic                   cur_v_q;
	logic [1:0]             cnt_q;
	logic                   adv;
	logic                   issue;
	logic                   is_wr;
	logic                   done;
	logic                   tap_en;
	logic                   wr_en;
	logic [AW-1:0]          addr;
	logic [3:0][MIX_W-1:0]  acc_q;

	logic                   v_s1, first_s1, last_s1, unl_s1, ok_s1;
	logic [W_W-1:0]         w_s1;
	logic [31:0]            rdata_s1;
	logic                   v_s2, first_s2, last_s2, unl_s2;
	logic [3:0][MIX_W-1:0]  prod_s2;
	logic                   v_s3, unl_s3;
	logic [3:0][MIX_W-1:0]  mix_s3;
	logic                   v_s4, unl_s4;
	logic [1:0]             neg_s4;
	logic [1:0][MIX_W-1:0]  mag_s4;
	logic [3:2][25:0]       x_s4;
	logic                   v_s5, unl_s5;
	logic [1:0]             neg_s5;
	logic [1:0][40:0]       ph_s5;
	logic [1:0][31:0]       pl_s5;
	logic [3:2][25:0]       x_s5;
	logic                   v_s6, unl_s6;
	logic [1:0]             neg_s6;
	logic [3:0][25:0]       z_s6;
	logic                   v_s7, unl_s7;
	logic [1:0]             neg_s7;
	logic [3:0][24:0]       y_s7;
	logic [3:0][17:0]       q0_s7;
	logic                   v_s8;
	logic [16:0]            velx_s8, vely_s8;
	logic [15:0]            dens_s8, solid_s8;

	logic [3:0][8:0]        chan;
	logic [3:0][MIX_W-1:0]  prod_d;
	logic [3:0][MIX_W-1:0]  sum_d;

	// tap sequencer
	assign adv    = !v_s8 || out_ready;
	assign is_wr  = cur_q.kind == KIND_WRITE;
	assign issue  = cur_v_q && adv;
	assign done   = issue && (is_wr || cur_q.unl || (cnt_q == 2'd3));
	assign q_ready = adv && (!cur_v_q || done);
	assign tap_en = issue && !is_wr;
	assign wr_en  = issue && is_wr && cur_q.ok[0];
	assign addr   = cur_q.lin[cnt_q][AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			cnt_q   <= 2'd0;
		end else if (q_valid && q_ready) begin
			cur_v_q <= 1'b1;
			cnt_q   <= 2'd0;
		end else if (done) begin
			cur_v_q <= 1'b0;
			cnt_q   <= 2'd0;
		end else if (issue) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			cur_q <= q_cmd;
		end
	end

	// single port texel memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tex_mem[addr] <= cur_q.bgra;
		end
		if (tap_en) begin
			rdata_s1 <= tex_mem[addr];
		end
	end

	// channel values, products and running sum
	always_comb begin
		if (ok_s1) begin
			chan[0] = {rdata_s1[23:16], 1'b0};
			chan[1] = {rdata_s1[15:8], 1'b0};
			chan[2] = {rdata_s1[7:0], 1'b0};
			chan[3] = {rdata_s1[31:24], 1'b0};
		end else begin
			chan[0] = OUTSIDE_RG;
			chan[1] = OUTSIDE_RG;
			chan[2] = 9'd0;
			chan[3] = 9'd0;
		end
		for (int c = 0; c < 4; c++) begin
			prod_d[c] = MIX_W'({33'd0, chan[c]} * {9'd0, w_s1});
			sum_d[c]  = first_s2 ? prod_s2[c] : MIX_W'(acc_q[c] + prod_s2[c]);
		end
	end

	// control of the back pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= tap_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && last_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// back pipeline payload
	always_ff @(posedge clk) begin
		logic [41:0] twom;
		logic [57:0] pp;
		logic [49:0] qp;
		logic [26:0] rr;
		logic [17:0] qq;
		if (adv) begin
			// tap token
			first_s1 <= cnt_q == 2'd0;
			last_s1  <= cur_q.unl || (cnt_q == 2'd3);
			unl_s1   <= cur_q.unl;
			ok_s1    <= cur_q.ok[cnt_q];
			w_s1     <= cur_q.w[cnt_q];
			// weighted channels
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			unl_s2   <= unl_s1;
			prod_s2  <= prod_d;
			// accumulate up to four taps
			unl_s3 <= unl_s2;
			if (v_s2) begin
				acc_q  <= sum_d;
				mix_s3 <= sum_d;
			end
			// velocity magnitude and sign, rounding offset for density and solid
			unl_s4 <= unl_s3;
			for (int c = 0; c < 2; c++) begin
				twom = {mix_s3[c], 1'b0};
				neg_s4[c] <= twom < MIX_FULL;
				mag_s4[c] <= (twom < MIX_FULL) ? MIX_W'(MIX_FULL - twom) : MIX_W'(twom - MIX_FULL);
			end
			for (int c = 2; c < 4; c++) begin
				x_s4[c] <= 26'(mix_s3[c][40:16]) + 26'd255;
			end
			// scale by vmax in two partial products
			unl_s5 <= unl_s4;
			neg_s5 <= neg_s4;
			x_s5   <= x_s4;
			for (int c = 0; c < 2; c++) begin
				ph_s5[c] <= 41'({16'd0, mag_s4[c][40:16]} * {25'd0, cfg.vmax});
				pl_s5[c] <= 32'({16'd0, mag_s4[c][15:0]} * {16'd0, cfg.vmax});
			end
			// sum partial products, keep the part above 2^32 with rounding offset
			unl_s6 <= unl_s5;
			neg_s6 <= neg_s5;
			for (int c = 0; c < 2; c++) begin
				pp = {1'b0, ph_s5[c], 16'h0000} + {26'd0, pl_s5[c]};
				z_s6[c] <= 26'(pp[57:32]) + 26'd255;
			end
			z_s6[2] <= x_s5[2];
			z_s6[3] <= x_s5[3];
			// divide by 510: halve, then estimate by the reciprocal of 255
			unl_s7 <= unl_s6;
			neg_s7 <= neg_s6;
			for (int c = 0; c < 4; c++) begin
				qp = {25'd0, z_s6[c][25:1]} * {25'd0, RECIP_255};
				y_s7[c]  <= z_s6[c][25:1];
				q0_s7[c] <= qp[49:32];
			end
			// correct the estimate, sign and saturate
			for (int c = 0; c < 4; c++) begin
				rr = {2'b00, y_s7[c]} - ({1'b0, q0_s7[c], 8'h00} - {9'd0, q0_s7[c]});
				qq = (rr >= 27'd255) ? q0_s7[c] + 18'd1 : q0_s7[c];
				case (c)
					0: velx_s8 <= unl_s7 ? 17'd0 : (neg_s7[0] ? 17'(-qq) : qq[16:0]);
					1: vely_s8 <= unl_s7 ? 17'd0 : (neg_s7[1] ? 17'(-qq) : qq[16:0]);
					2: dens_s8 <= unl_s7 ? 16'd0 : ((qq > 18'd65535) ? 16'hFFFF : qq[15:0]);
					3: solid_s8 <= (unl_s7 || (qq > 18'd65535)) ? 16'hFFFF : qq[15:0];
					default: solid_s8 <= 16'hFFFF;
				endcase
			end
		end
	end

	assign out_valid = v_s8;
	assign vel_x     = velx_s8;
	assign vel_y     = vely_s8;
	assign density   = dens_s8;
	assign solid     = solid_s8;

`ifndef SYNTHESIS
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!cur_v_q |-> cnt_q == 2'd0)
		else $error("tap counter left running without a request");
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !tap_en)
		else $error("memory write and tap read in one cycle");
	a_last_tap: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && last_s2 && adv) |=> v_s3)
		else $error("last tap did not produce a mixed result");
`endif

endmodule

/* rtl/flipbook_bilinear_sampler_unit.sv */
// top level: register port, front end, request queue and back end
// throughput: one texel write per cycle when the output does not stall; a sample
// issues up to four tap reads, which share the single port of the texel memory,
// and the next request starts once the last tap of the current one is issued
// reset: registers return to their defaults and all pipelines empty at once;
// the texel memory is not cleared and holds nothing usable until written
module flipbook_bilinear_sampler_unit #(
	parameter int MAX_TEXELS = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // texel_index, texel_bgra, u, v, frame
	input  logic [0:0]   s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,  // vel_x, vel_y, density, solid
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import fbs_pkg::*;

	cfg_t        cfg_q;
	logic        fq_valid, fq_ready;
	cmd_t        fq_cmd;
	logic        qb_valid, qb_ready;
	cmd_t        qb_cmd;
	logic [16:0] vel_x, vel_y;
	logic [15:0] density, solid;
	logic [2:0]  reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[4:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_n        <= 9'd64;
			cfg_q.tiles_per_row <= 9'd4;
			cfg_q.frame_count   <= 11'd16;
			cfg_q.field_width   <= 13'd256;
			cfg_q.field_height  <= 13'd256;
			cfg_q.vmax          <= 16'd256;
			cfg_q.field_loaded  <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_GRID_N:        cfg_q.grid_n        <= pwdata[8:0];
				REG_TILES_PER_ROW: cfg_q.tiles_per_row <= pwdata[8:0];
				REG_FRAME_COUNT:   cfg_q.frame_count   <= pwdata[10:0];
				REG_FIELD_WIDTH:   cfg_q.field_width   <= pwdata[12:0];
				REG_FIELD_HEIGHT:  cfg_q.field_height  <= pwdata[12:0];
				REG_VMAX:          cfg_q.vmax          <= pwdata[15:0];
				REG_FIELD_LOADED:  cfg_q.field_loaded  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_sel)
			REG_GRID_N:        prdata = 32'(cfg_q.grid_n);
			REG_TILES_PER_ROW: prdata = 32'(cfg_q.tiles_per_row);
			REG_FRAME_COUNT:   prdata = 32'(cfg_q.frame_count);
			REG_FIELD_WIDTH:   prdata = 32'(cfg_q.field_width);
			REG_FIELD_HEIGHT:  prdata = 32'(cfg_q.field_height);
			REG_VMAX:          prdata = 32'(cfg_q.vmax);
			REG_FIELD_LOADED:  prdata = 32'(cfg_q.field_loaded);
			default:           prdata = 32'd0;
		endcase
	end

	fbs_front #(.MAX_TEXELS(MAX_TEXELS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser[0]),
		.in_idx    (s_tdata[15:0]),
		.in_bgra   (s_tdata[47:16]),
		.in_u      (s_tdata[65:48]),
		.in_v      (s_tdata[83:66]),
		.in_frame  (s_tdata[93:84]),
		.out_valid (fq_valid),
		.out_ready (fq_ready),
		.out_cmd   (fq_cmd)
	);

	fbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_cmd    (fq_cmd),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_cmd   (qb_cmd)
	);

	fbs_back #(.MAX_TEXELS(MAX_TEXELS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (qb_valid),
		.q_ready   (qb_ready),
		.q_cmd     (qb_cmd),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.density   (density),
		.solid     (solid)
	);

	assign m_tdata = {6'd0, solid, density, vel_y, vel_x};

endmodule
